// ----- design/http_request_header_parser_assert.svh -----
// Assertion macros used by the parser RTL.
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH

// Implication checked in the same cycle.
`define HRP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the following cycle.
`define HRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/hrp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, constants and string helpers for the HTTP request header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrp_pkg;

  localparam int unsigned LengthBitsDefault = 24;
  localparam int unsigned IdxBits = 6;
  localparam logic [IdxBits-1:0] IdxMax = '1;

  typedef enum logic [3:0] {
    PH_METHOD  = 4'd0,
    PH_PATH    = 4'd1,
    PH_REQLINE = 4'd2,
    PH_NAME    = 4'd4,
    PH_VSPACE  = 4'd5,
    PH_HOST    = 4'd6,
    PH_CKNAME  = 4'd7,
    PH_CKVAL   = 4'd8,
    PH_CKSPACE = 4'd9,
    PH_CONN    = 4'd10,
    PH_CLEN    = 4'd11,
    PH_OTHER   = 4'd12,
    PH_BODY    = 4'd13
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PATH    = 3'd0,
    KIND_HOST    = 3'd1,
    KIND_SESSION = 3'd2,
    KIND_SUMMARY = 3'd3,
    KIND_BODY    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    METH_GET     = 2'd0,
    METH_POST    = 2'd1,
    METH_UNKNOWN = 2'd2
  } method_e;

  typedef struct packed {
    phase_e             phase;
    logic [IdxBits-1:0] match_idx;
    logic [3:0]         name_cand;
    logic [1:0]         meth_cand;
    logic               ck_session;
    logic               ka_match;
    method_e            method_code;
    logic               ka_flag;
    logic               pending_cr;
    logic [7:0]         held_byte;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic        last;
    method_e     method;
    logic        keep_alive;
    logic [23:0] body_length;
  } result_t;

  localparam state_t StateReset = '{
    phase: PH_METHOD, match_idx: '0, name_cand: 4'hF, meth_cand: 2'b11,
    ck_session: 1'b0, ka_match: 1'b0, method_code: METH_UNKNOWN,
    ka_flag: 1'b0, pending_cr: 1'b0, held_byte: 8'h00
  };

  localparam logic [127:0] StrGet     = "GET";
  localparam logic [127:0] StrPost    = "POST";
  localparam logic [127:0] StrHost    = "Host";
  localparam logic [127:0] StrCookie  = "Cookie";
  localparam logic [127:0] StrSession = "session";
  localparam logic [127:0] StrConn    = "Connection";
  localparam logic [127:0] StrKeep    = "keep-alive";
  localparam logic [127:0] StrClen    = "Content-Length";

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChFf    = 8'h0C;

  // True when the byte equals character idx of a keyword of length len.
  function automatic logic kw_hit(input logic [127:0] s, input logic [IdxBits-1:0] len,
                                  input logic [IdxBits-1:0] idx, input logic [7:0] b);
    int unsigned pos;
    logic hit;
    pos = 8 * (int'(len) - 1 - int'(idx));
    hit = 1'b0;
    if (idx < len) begin
      hit = (s[pos+:8] == b);
    end
    return hit;
  endfunction

endpackage

// ----- design/http_request_header_parser.sv -----
// A result is loaded into the output register when its byte is accepted.
// Throughput: one byte per cycle while the output is not stalled; the parse step is a single combinational pass.
// A byte is accepted whenever the output register is empty or is being drained.
// Reset: rst_ni clears the parse state to the method phase and empties the output.
// ----------------------------------------------------------------------------
// http_request_header_parser
// Byte-wide HTTP request header parser with registered state and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "http_request_header_parser_assert.svh"

module http_request_header_parser #(
  parameter int unsigned LengthBits = hrp_pkg::LengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [1:0]  method_o,
  output logic        keep_alive_o,
  output logic [23:0] body_length_o
);
  import hrp_pkg::*;

  state_t                st_q, st_d;
  logic [LengthBits-1:0] acc_q, acc_d;
  logic [LengthBits-1:0] rem_q, rem_d;
  logic                  res_valid;
  result_t               res;
  result_t               out_q;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;

  hrp_step #(.LenBits(LengthBits)) u_step (
    .st_i        (st_q),
    .acc_i       (acc_q),
    .rem_i       (rem_q),
    .data_byte_i (data_byte_i),
    .restart_i   (restart_i),
    .st_o        (st_d),
    .acc_o       (acc_d),
    .rem_o       (rem_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StateReset;
      acc_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        st_q  <= st_d;
        acc_q <= acc_d;
        rem_q <= rem_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign out_byte_o    = out_q.out_byte;
  assign last_o        = out_q.last;
  assign method_o      = out_q.method;
  assign keep_alive_o  = out_q.keep_alive;
  assign body_length_o = out_q.body_length;

  `HRP_ASSERT_IMPL(a_summary_last, out_valid_o && kind_o == KIND_SUMMARY, last_o)
  `HRP_ASSERT_IMPL(a_plain_no_meta, out_valid_o && kind_o != KIND_SUMMARY,
                   method_o == METH_GET && !keep_alive_o && body_length_o == 24'd0)
  `HRP_ASSERT_IMPL(a_ready_when_empty, !out_valid_o, in_ready_o)
  `HRP_ASSERT_NEXT(a_result_loaded, accept && res_valid, out_valid_o)

endmodule

// ----- design/hrp_step.sv -----
// ----------------------------------------------------------------------------
// hrp_step
// Next-state and result logic of the parser for one request byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrp_step #(
  parameter int unsigned LenBits = hrp_pkg::LengthBitsDefault
) (
  input  hrp_pkg::state_t st_i,
  input  logic [LenBits-1:0] acc_i,
  input  logic [LenBits-1:0] rem_i,
  input  logic [7:0]         data_byte_i,
  input  logic               restart_i,
  output hrp_pkg::state_t    st_o,
  output logic [LenBits-1:0] acc_o,
  output logic [LenBits-1:0] rem_o,
  output logic               res_valid_o,
  output hrp_pkg::result_t   res_o
);
  import hrp_pkg::*;

  state_t             s;
  logic [LenBits-1:0] acc;
  logic [LenBits-1:0] rem;
  logic [LenBits+3:0] prod;
  logic [31:0]        acc32;
  logic [7:0]         b;
  logic               done;
  logic               go_val;
  logic               rv;
  result_t            r;

  always_comb begin
    s      = st_i;
    acc    = acc_i;
    rem    = rem_i;
    b      = data_byte_i;
    done   = 1'b0;
    go_val = 1'b0;
    rv     = 1'b0;
    r      = '0;
    prod   = ({4'b0, acc_i} << 3) + ({4'b0, acc_i} << 1) + (LenBits+4)'(b - ChZero);
    acc32  = 32'(acc_i);
    if (restart_i) begin
      s   = StateReset;
      acc = '0;
      rem = '0;
    end
    case (s.phase)
      PH_METHOD: begin
        if (b == ChSpace) begin
          if (s.meth_cand[0] && s.match_idx == 6'd3) begin
            s.method_code = METH_GET;
          end else if (s.meth_cand[1] && s.match_idx == 6'd4) begin
            s.method_code = METH_POST;
          end else begin
            s.method_code = METH_UNKNOWN;
          end
          s.match_idx = '0;
          s.phase     = PH_PATH;
        end else begin
          if (!kw_hit(StrGet, 6'd3, s.match_idx, b)) s.meth_cand[0] = 1'b0;
          if (!kw_hit(StrPost, 6'd4, s.match_idx, b)) s.meth_cand[1] = 1'b0;
          if (s.match_idx != IdxMax) s.match_idx = s.match_idx + 6'd1;
        end
      end
      PH_PATH: begin
        if (b == ChSpace) begin
          if (s.match_idx != '0) begin
            rv = 1'b1; r.kind = KIND_PATH; r.out_byte = s.held_byte; r.last = 1'b1;
            s.match_idx = '0;
          end
          s.phase = PH_REQLINE;
        end else begin
          if (s.match_idx != '0) begin
            rv = 1'b1; r.kind = KIND_PATH; r.out_byte = s.held_byte;
          end
          s.held_byte = b;
          s.match_idx = 6'd1;
        end
      end
      PH_BODY: begin
        rem = rem - LenBits'(1);
        rv = 1'b1; r.kind = KIND_BODY; r.out_byte = b; r.last = (rem == '0);
        if (rem == '0) begin
          s   = StateReset;
          acc = '0;
        end
      end
      default: begin
        if (s.pending_cr) begin
          s.pending_cr = 1'b0;
          if (b == ChLf) begin
            done = 1'b1;
            if (s.phase == PH_NAME && s.match_idx == '0) begin
              rv = 1'b1; r.kind = KIND_SUMMARY; r.last = 1'b1;
              r.method = s.method_code; r.keep_alive = s.ka_flag;
              r.body_length = (acc32 > 32'hFFFFFF) ? 24'hFFFFFF : acc32[23:0];
              if (acc == '0) begin
                s   = StateReset;
                rem = '0;
              end else begin
                rem     = acc;
                s.phase = PH_BODY;
              end
            end else begin
              case (s.phase)
                PH_VSPACE: begin
                  if (s.name_cand[2]) s.ka_flag = 1'b0;
                  if (s.name_cand[3]) acc = '0;
                end
                PH_HOST: begin
                  if (s.match_idx != '0) begin
                    rv = 1'b1; r.kind = KIND_HOST; r.out_byte = s.held_byte; r.last = 1'b1;
                  end
                end
                PH_CKVAL: begin
                  if (s.ck_session && s.match_idx != '0) begin
                    rv = 1'b1; r.kind = KIND_SESSION; r.out_byte = s.held_byte;
                    r.last = 1'b1;
                  end
                end
                PH_CONN: s.ka_flag = s.ka_match && (s.match_idx == 6'd10);
                default: ;
              endcase
              s.phase     = PH_NAME;
              s.match_idx = '0;
              s.name_cand = 4'hF;
            end
          end
        end
        if (!done && b == ChCr) begin
          s.pending_cr = 1'b1;
          done = 1'b1;
        end
        if (!done) begin
          case (s.phase)
            PH_NAME: begin
              if (b == ChColon) begin
                s.name_cand = s.name_cand & {s.match_idx == 6'd14, s.match_idx == 6'd10,
                                             s.match_idx == 6'd6, s.match_idx == 6'd4};
                s.phase = PH_VSPACE;
              end else begin
                if (!kw_hit(StrHost, 6'd4, s.match_idx, b)) s.name_cand[0] = 1'b0;
                if (!kw_hit(StrCookie, 6'd6, s.match_idx, b)) s.name_cand[1] = 1'b0;
                if (!kw_hit(StrConn, 6'd10, s.match_idx, b)) s.name_cand[2] = 1'b0;
                if (!kw_hit(StrClen, 6'd14, s.match_idx, b)) s.name_cand[3] = 1'b0;
                if (s.match_idx != IdxMax) s.match_idx = s.match_idx + 6'd1;
              end
            end
            PH_VSPACE: begin
              if (b != ChSpace) begin
                s.match_idx = '0;
                go_val = 1'b1;
                if (s.name_cand[0]) begin
                  s.phase = PH_HOST;
                end else if (s.name_cand[1]) begin
                  s.phase = PH_CKNAME;
                  s.ck_session = 1'b1;
                end else if (s.name_cand[2]) begin
                  s.phase = PH_CONN;
                  s.ka_match = 1'b1;
                end else if (s.name_cand[3]) begin
                  s.phase = PH_CLEN;
                  acc = '0;
                  prod = (LenBits+4)'(b - ChZero);
                end else begin
                  s.phase = PH_OTHER;
                end
              end
            end
            PH_REQLINE: ;
            default: go_val = 1'b1;
          endcase
        end
        if (go_val) begin
          if (s.phase == PH_CKSPACE && b != ChSpace) begin
            s.phase = PH_CKNAME;
            s.ck_session = 1'b1;
            s.match_idx = '0;
          end
          case (s.phase)
            PH_HOST: begin
              if (s.match_idx != '0) begin
                rv = 1'b1; r.kind = KIND_HOST; r.out_byte = s.held_byte;
              end
              s.held_byte = b;
              s.match_idx = 6'd1;
            end
            PH_CKNAME: begin
              if (b == ChEq) begin
                s.ck_session = s.ck_session && (s.match_idx == 6'd7);
                s.match_idx = '0;
                s.phase = PH_CKVAL;
              end else if (b == ChSemi) begin
                s.phase = PH_CKSPACE;
              end else begin
                if (!kw_hit(StrSession, 6'd7, s.match_idx, b)) s.ck_session = 1'b0;
                if (s.match_idx != IdxMax) s.match_idx = s.match_idx + 6'd1;
              end
            end
            PH_CKVAL: begin
              if (b == ChSemi) begin
                if (s.ck_session && s.match_idx != '0) begin
                  rv = 1'b1; r.kind = KIND_SESSION; r.out_byte = s.held_byte; r.last = 1'b1;
                end
                s.match_idx = '0;
                s.phase = PH_CKSPACE;
              end else if (s.ck_session) begin
                if (s.match_idx != '0) begin
                  rv = 1'b1; r.kind = KIND_SESSION; r.out_byte = s.held_byte;
                end
                s.held_byte = b;
                s.match_idx = 6'd1;
              end
            end
            PH_CONN: begin
              if (!kw_hit(StrKeep, 6'd10, s.match_idx, b)) s.ka_match = 1'b0;
              if (s.match_idx != IdxMax) s.match_idx = s.match_idx + 6'd1;
            end
            PH_CLEN: begin
              if (s.match_idx != 6'd2) begin
                if (b >= ChZero && b <= ChNine) begin
                  acc = (prod[LenBits+3:LenBits] != '0) ? '1 : prod[LenBits-1:0];
                  s.match_idx = 6'd1;
                end else if (s.match_idx == '0 &&
                             (b == ChSpace || (b >= ChTab && b <= ChFf))) begin
                  s.match_idx = '0;
                end else if (s.match_idx == '0 && b == ChPlus) begin
                  s.match_idx = 6'd1;
                end else begin
                  if (s.match_idx == '0 && b == ChMinus) acc = '0;
                  s.match_idx = 6'd2;
                end
              end
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  assign st_o        = s;
  assign acc_o       = acc;
  assign rem_o       = rem;
  assign res_valid_o = rv;
  assign res_o       = r;

endmodule
